### sv/keyed_symbol_table_assert.svh
// Assertion macros shared by the keyed symbol table checkers.
`ifndef KEYED_SYMBOL_TABLE_ASSERT_SVH
`define KEYED_SYMBOL_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define KST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define KST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### sv/kst_pkg.sv
// Types and constants shared by the keyed symbol table modules.
package kst_pkg;

    // Fixed widths of the stream fields.
    localparam int FIELD_W    = 64;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 3;
    localparam int IN_DATA_W  = 3 * FIELD_W;
    localparam int OUT_DATA_W = 3 * FIELD_W;

    // Operation codes carried with each input item.
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_LIST   = 2'd1,
        OP_SEARCH = 2'd2,
        OP_DELETE = 2'd3
    } t_op;

    // Status codes carried with each result item.
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_DELETED   = 3'd5,
        ST_EMPTY     = 3'd6,
        ST_ENTRY     = 3'd7
    } t_status;

    // Sequencer states of the table controller.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_LIST,
        S_EMIT
    } t_state;

endpackage

### sv/kst_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module kst_ram #(
    parameter int WIDTH = 192,
    parameter int DEPTH = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                         i_wr_data,
    input  logic                                     i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/keyed_symbol_table.sv
// Keyed symbol table: packed entries in one RAM, searched and shifted in turn.
//
// Input channel (i_s_*): one item per operation. tuser carries the operation
// (insert, list, search, delete); tdata carries the key, type and value texts,
// each in a 64-bit lane of which the low TEXT_BITS are used.
// Output channel (o_m_*): result items. tuser carries the status, tdata the
// name, type and value of a found or listed entry (zero otherwise), tlast
// marks the final result of an operation.
// Insert, search and delete give one result; list gives one result per entry,
// or a single empty status when nothing is stored.
// Flow: one item at a time; the scan reads one RAM entry per cycle, so an insert
// or a missed search reads every stored entry, and a hit ends the search early.
// Delete moves any later entries down one place through the same ports. List
// streams one entry per cycle when the receiver keeps up.
// Results leave through an output register, so a new item is taken while the
// previous result still waits. A stalled receiver holds the result; a list
// pauses its reads until the register frees.
// Reset empties the table at once; the RAM contents need no clearing.
module keyed_symbol_table #(
    parameter int DEPTH     = 32,
    parameter int TEXT_BITS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [kst_pkg::IN_DATA_W-1:0]    i_s_tdata,  // key_name, type_text, value_text
    input  logic [kst_pkg::OP_W-1:0]         i_s_tuser,  // op
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [kst_pkg::OUT_DATA_W-1:0]   o_m_tdata,  // out_name, out_type, out_value
    output logic [kst_pkg::STATUS_W-1:0]     o_m_tuser,  // status
    output logic                             o_m_tlast   // last
);

    import kst_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = 3 * TEXT_BITS;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    // Control registers.
    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_rd_vld, n_rd_vld;
    logic                  r_out_valid, n_out_valid;

    // Payload registers.
    t_op                   r_op, n_op;
    logic [TEXT_BITS-1:0]  r_key, n_key;
    logic [TEXT_BITS-1:0]  r_type, n_type;
    logic [TEXT_BITS-1:0]  r_value, n_value;
    logic [CW-1:0]         r_issue, n_issue;
    logic [IW-1:0]         r_rd_idx, n_rd_idx;
    t_status               r_res_status, n_res_status;
    logic [EW-1:0]         r_res_data, n_res_data;
    t_status               r_out_status, n_out_status;
    logic [EW-1:0]         r_out_data, n_out_data;
    logic                  r_out_last, n_out_last;

    // RAM ports.
    logic                  rd_en;
    logic [IW-1:0]         rd_addr;
    logic [EW-1:0]         rd_data;
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [EW-1:0]         wr_data;

    logic                  out_free;
    logic                  issue_more;
    logic                  hit;
    logic                  list_load;

    // Entry storage: value, type, name from the top bits down.
    kst_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_entries (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign out_free   = !r_out_valid || i_m_tready;
    assign issue_more = (r_issue < r_count);
    assign hit        = r_rd_vld && (rd_data[TEXT_BITS-1:0] == r_key);
    assign list_load  = r_rd_vld && out_free;

    // Sequencer: next state, RAM accesses and result loading.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_rd_vld     = r_rd_vld;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_op         = r_op;
        n_key        = r_key;
        n_type       = r_type;
        n_value      = r_value;
        n_issue      = r_issue;
        n_rd_idx     = r_rd_idx;
        n_res_status = r_res_status;
        n_res_data   = r_res_data;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        n_out_last   = r_out_last;
        rd_en        = 1'b0;
        rd_addr      = r_issue[IW-1:0];
        wr_en        = 1'b0;
        wr_addr      = r_count[IW-1:0];
        wr_data      = {r_value, r_type, r_key};
        o_s_tready   = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_op     = t_op'(i_s_tuser);
                    n_key    = i_s_tdata[TEXT_BITS-1:0];
                    n_type   = i_s_tdata[FIELD_W +: TEXT_BITS];
                    n_value  = i_s_tdata[2*FIELD_W +: TEXT_BITS];
                    n_issue  = '0;
                    n_rd_vld = 1'b0;
                    if (t_op'(i_s_tuser) == OP_LIST) begin
                        if (r_count == '0) begin
                            n_res_status = ST_EMPTY;
                            n_res_data   = '0;
                            n_state      = S_EMIT;
                        end else begin
                            n_state = S_LIST;
                        end
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            // Read entries in turn and compare each name in the cycle after its read.
            S_SCAN: begin
                if (hit) begin
                    n_rd_vld   = 1'b0;
                    n_res_data = '0;
                    n_state    = S_EMIT;
                    case (r_op)
                        OP_INSERT: begin
                            n_res_status = ST_DUPLICATE;
                        end
                        OP_SEARCH: begin
                            n_res_status = ST_FOUND;
                            n_res_data   = rd_data;
                        end
                        OP_DELETE: begin
                            n_issue = CW'(r_rd_idx) + CW'(1);
                            n_state = S_SHIFT;
                        end
                        default: begin
                            n_res_status = ST_NOT_FOUND;
                        end
                    endcase
                end else if (issue_more) begin
                    rd_en    = 1'b1;
                    n_issue  = r_issue + CW'(1);
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_issue[IW-1:0];
                end else begin
                    n_rd_vld = 1'b0;
                    if (!r_rd_vld) begin
                        // Every entry checked without a match.
                        n_res_data = '0;
                        n_state    = S_EMIT;
                        if (r_op == OP_INSERT) begin
                            if (r_count >= FULL_COUNT) begin
                                n_res_status = ST_FULL;
                            end else begin
                                wr_en        = 1'b1;
                                n_count      = r_count + CW'(1);
                                n_res_status = ST_INSERTED;
                            end
                        end else begin
                            n_res_status = ST_NOT_FOUND;
                        end
                    end
                end
            end

            // Move each later entry down one place: read it, write it back below.
            S_SHIFT: begin
                if (r_rd_vld) begin
                    wr_en   = 1'b1;
                    wr_addr = r_rd_idx - IW'(1);
                    wr_data = rd_data;
                end
                if (issue_more) begin
                    rd_en    = 1'b1;
                    n_issue  = r_issue + CW'(1);
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_issue[IW-1:0];
                end else begin
                    n_rd_vld = 1'b0;
                    if (!r_rd_vld) begin
                        n_count      = r_count - CW'(1);
                        n_res_status = ST_DELETED;
                        n_res_data   = '0;
                        n_state      = S_EMIT;
                    end
                end
            end

            // Stream entries out; reads pause while the output register is full.
            S_LIST: begin
                if (list_load) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_ENTRY;
                    n_out_data   = rd_data;
                    n_out_last   = ((CW'(r_rd_idx) + CW'(1)) == r_count);
                end
                if (!r_rd_vld || list_load) begin
                    if (issue_more) begin
                        rd_en    = 1'b1;
                        n_issue  = r_issue + CW'(1);
                        n_rd_vld = 1'b1;
                        n_rd_idx = r_issue[IW-1:0];
                    end else begin
                        n_rd_vld = 1'b0;
                        if (!r_rd_vld) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end

            // Hand the single result to the output register.
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_data   = r_res_data;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_type       <= n_type;
        r_value      <= n_value;
        r_issue      <= n_issue;
        r_rd_idx     <= n_rd_idx;
        r_res_status <= n_res_status;
        r_res_data   <= n_res_data;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
        r_out_last   <= n_out_last;
    end

    // Output channel, each text zero extended to its 64-bit lane.
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {FIELD_W'(r_out_data[2*TEXT_BITS +: TEXT_BITS]),
                         FIELD_W'(r_out_data[TEXT_BITS +: TEXT_BITS]),
                         FIELD_W'(r_out_data[TEXT_BITS-1:0])};

endmodule

### sv/kst_checker.sv
// Port-level checks of the keyed symbol table and their binding to the top level.
`include "keyed_symbol_table_assert.svh"

module kst_port_checks (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic [kst_pkg::IN_DATA_W-1:0]    i_s_tdata,
    input logic [kst_pkg::OP_W-1:0]         i_s_tuser,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [kst_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    input logic [kst_pkg::STATUS_W-1:0]     o_m_tuser,
    input logic                             o_m_tlast
);

    import kst_pkg::*;

    // A stalled result keeps its contents.
    `KST_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast), "result changed while stalled")

    // Only found and listed entries carry data.
    `KST_ASSERT_NOW(a_zero_data, o_m_tvalid && o_m_tuser != ST_FOUND && o_m_tuser != ST_ENTRY, o_m_tdata == '0, "status result carries nonzero data")

    // Every result other than a listed entry ends its operation.
    `KST_ASSERT_NOW(a_single_last, o_m_tvalid && o_m_tuser != ST_ENTRY, o_m_tlast, "single result without last")

    // The table works on one item at a time.
    `KST_ASSERT_NEXT(a_one_item, i_s_tvalid && o_s_tready, !o_s_tready, "item taken while busy")

endmodule

bind keyed_symbol_table kst_port_checks u_kst_port_checks (.*);

### tb/sv/kst_checker.sv
// Checker for the keyed symbol table: shadow table, result prediction and comparison.
module kst_checker #(
    parameter int DEPTH     = 32,
    parameter int TEXT_BITS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    input  logic [kst_pkg::IN_DATA_W-1:0]    i_s_tdata,  // key_name, type_text, value_text
    input  logic [kst_pkg::OP_W-1:0]         i_s_tuser,  // op
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    input  logic [kst_pkg::OUT_DATA_W-1:0]   i_m_tdata,  // out_name, out_type, out_value
    input  logic [kst_pkg::STATUS_W-1:0]     i_m_tuser,  // status
    input  logic                             i_m_tlast,  // last
    output int                               o_fail_count,
    output int                               o_awaited,
    output int                               o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import kst_pkg::*;

    localparam logic [FIELD_W-1:0] TEXT_MASK =
        (TEXT_BITS >= FIELD_W) ? {FIELD_W{1'b1}} : ((64'd1 << TEXT_BITS) - 64'd1);

    // One expected result item.
    typedef struct {
        t_status            status;
        logic [FIELD_W-1:0] name;
        logic [FIELD_W-1:0] ty_text;
        logic [FIELD_W-1:0] value;
        logic               last;
    } t_table_row;

    // Shadow copy of the table contents.
    logic [FIELD_W-1:0] shadow_names  [DEPTH];
    logic [FIELD_W-1:0] shadow_types  [DEPTH];
    logic [FIELD_W-1:0] shadow_values [DEPTH];
    int                 shadow_count;

    t_table_row awaited_rows[$];

    initial begin
        o_fail_count = 0;
        o_awaited    = 0;
        o_checked    = 0;
        shadow_count = 0;
    end

    task automatic report_mismatch(string what, logic [FIELD_W-1:0] got,
                                   logic [FIELD_W-1:0] want);
        $display("MISMATCH at result %0d, %s: got %h, want %h", o_checked, what, got, want);
        o_fail_count++;
    endtask

    function automatic int find_slot(logic [FIELD_W-1:0] key);
        for (int i = 0; i < shadow_count; i++) begin
            if (shadow_names[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void push_row(t_status status, logic [FIELD_W-1:0] name,
                                     logic [FIELD_W-1:0] ty_text,
                                     logic [FIELD_W-1:0] value, logic last);
        t_table_row row;
        row.status  = status;
        row.name    = name;
        row.ty_text = ty_text;
        row.value   = value;
        row.last    = last;
        awaited_rows.push_back(row);
    endfunction

    // Applies one operation to the shadow table and queues the results it causes.
    task automatic apply_table_op(t_op op, logic [FIELD_W-1:0] key_in,
                                  logic [FIELD_W-1:0] ty_in, logic [FIELD_W-1:0] va_in);
        logic [FIELD_W-1:0] key;
        logic [FIELD_W-1:0] ty_text;
        logic [FIELD_W-1:0] value;
        int                 slot;
        key     = key_in & TEXT_MASK;
        ty_text = ty_in & TEXT_MASK;
        value   = va_in & TEXT_MASK;
        slot    = find_slot(key);
        case (op)
            OP_INSERT: begin
                // A present key wins over a full table.
                if (slot >= 0) begin
                    push_row(ST_DUPLICATE, '0, '0, '0, 1'b1);
                end else if (shadow_count >= DEPTH) begin
                    push_row(ST_FULL, '0, '0, '0, 1'b1);
                end else begin
                    shadow_names[shadow_count]  = key;
                    shadow_types[shadow_count]  = ty_text;
                    shadow_values[shadow_count] = value;
                    shadow_count++;
                    push_row(ST_INSERTED, '0, '0, '0, 1'b1);
                end
            end
            OP_LIST: begin
                if (shadow_count == 0) begin
                    push_row(ST_EMPTY, '0, '0, '0, 1'b1);
                end else begin
                    for (int i = 0; i < shadow_count; i++) begin
                        push_row(ST_ENTRY, shadow_names[i], shadow_types[i],
                                 shadow_values[i], i == shadow_count - 1);
                    end
                end
            end
            OP_SEARCH: begin
                if (slot < 0) begin
                    push_row(ST_NOT_FOUND, '0, '0, '0, 1'b1);
                end else begin
                    push_row(ST_FOUND, shadow_names[slot], shadow_types[slot],
                             shadow_values[slot], 1'b1);
                end
            end
            default: begin
                // Delete closes the gap by moving the tail down one place.
                if (slot < 0) begin
                    push_row(ST_NOT_FOUND, '0, '0, '0, 1'b1);
                end else begin
                    for (int i = slot; i + 1 < shadow_count; i++) begin
                        shadow_names[i]  = shadow_names[i + 1];
                        shadow_types[i]  = shadow_types[i + 1];
                        shadow_values[i] = shadow_values[i + 1];
                    end
                    shadow_count--;
                    push_row(ST_DELETED, '0, '0, '0, 1'b1);
                end
            end
        endcase
    endtask

    // Watch both channels on every rising edge.
    always @(posedge i_clk) begin
        t_table_row want;
        if (!i_rst_n) begin
            shadow_count = 0;
            awaited_rows.delete();
        end else begin
            // Compare each accepted result with the oldest expectation.
            if (i_m_tvalid && i_m_tready) begin
                if (awaited_rows.size() == 0) begin
                    report_mismatch("unexpected result, status", FIELD_W'(i_m_tuser), '0);
                end else begin
                    want = awaited_rows.pop_front();
                    if (i_m_tuser != want.status) begin
                        report_mismatch("status", FIELD_W'(i_m_tuser),
                                        FIELD_W'(want.status));
                    end
                    if (i_m_tdata[FIELD_W-1:0] != want.name) begin
                        report_mismatch("out_name", i_m_tdata[FIELD_W-1:0], want.name);
                    end
                    if (i_m_tdata[2*FIELD_W-1:FIELD_W] != want.ty_text) begin
                        report_mismatch("out_type", i_m_tdata[2*FIELD_W-1:FIELD_W],
                                        want.ty_text);
                    end
                    if (i_m_tdata[3*FIELD_W-1:2*FIELD_W] != want.value) begin
                        report_mismatch("out_value", i_m_tdata[3*FIELD_W-1:2*FIELD_W],
                                        want.value);
                    end
                    if (i_m_tlast != want.last) begin
                        report_mismatch("last", FIELD_W'(i_m_tlast), FIELD_W'(want.last));
                    end
                end
                o_checked++;
            end
            // Predict the results of each accepted item.
            if (i_s_tvalid && i_s_tready) begin
                apply_table_op(t_op'(i_s_tuser), i_s_tdata[FIELD_W-1:0],
                               i_s_tdata[2*FIELD_W-1:FIELD_W],
                               i_s_tdata[3*FIELD_W-1:2*FIELD_W]);
            end
        end
        o_awaited <= awaited_rows.size();
    end

endmodule

### tb/sv/tb.sv
// Top of the keyed symbol table testbench: clock, reset, stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kst_pkg::*;

    localparam int DEPTH        = 32;
    localparam int TEXT_BITS    = 64;
    localparam int POOL_SIZE    = 48;
    localparam int RANDOM_ITEMS = 480;
    localparam int ROUND_LEN    = 40;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 100;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;   // key_name, type_text, value_text
    logic [OP_W-1:0]       s_tuser  = OP_INSERT;   // op
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // out_name, out_type, out_value
    logic [STATUS_W-1:0]   m_tuser;         // status
    logic                  m_tlast;         // last
    logic                  calm     = 1'b0;

    int fail_count;
    int awaited;
    int checked;
    int idle_cycles = 0;
    int op_tally[4] = '{0, 0, 0, 0};
    logic [FIELD_W-1:0] key_pool[POOL_SIZE];

    keyed_symbol_table #(
        .DEPTH     (DEPTH),
        .TEXT_BITS (TEXT_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    kst_checker #(
        .DEPTH     (DEPTH),
        .TEXT_BITS (TEXT_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_awaited    (awaited),
        .o_checked    (checked)
    );

    always #6 i_clk = ~i_clk;

    // The receiver stalls on about ten percent of cycles, never while calm.
    always @(posedge i_clk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 10);
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("keyed_symbol_table: mismatch");
            $finish;
        end
    end

    // Offers one item after an optional random gap and returns once it is taken.
    task automatic send_op(t_op op, logic [FIELD_W-1:0] key,
                           logic [FIELD_W-1:0] ty_text, logic [FIELD_W-1:0] value);
        while (!calm && $urandom_range(0, 99) < 10) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {value, ty_text, key};
        s_tuser  <= op;
        do begin
            @(posedge i_clk);
        end while (!s_tready);
        op_tally[op]++;
    endtask

    // Holds the sender off until every expected result has arrived.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (awaited != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [FIELD_W-1:0] random_text();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly keys from the pool so that hits, duplicates and deletes happen.
    function automatic logic [FIELD_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 85) begin
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        return {$urandom, $urandom};
    endfunction

    // Operation mix: growth favors inserts, drain favors deletes.
    function automatic t_op pick_op(int mode);
        int roll;
        roll = $urandom_range(0, 99);
        case (mode)
            0: begin
                if (roll < 70) return OP_INSERT;
                if (roll < 80) return OP_SEARCH;
                if (roll < 90) return OP_DELETE;
                return OP_LIST;
            end
            1: begin
                if (roll < 35) return OP_INSERT;
                if (roll < 62) return OP_SEARCH;
                if (roll < 90) return OP_DELETE;
                return OP_LIST;
            end
            default: begin
                if (roll < 15) return OP_INSERT;
                if (roll < 35) return OP_SEARCH;
                if (roll < 90) return OP_DELETE;
                return OP_LIST;
            end
        endcase
    endfunction

    initial begin
        int sent;
        int round;
        int mode;
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = {$urandom, $urandom};
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, extreme keys and texts, duplicates, shifts.
        send_op(OP_LIST,   '0, '0, '0);
        send_op(OP_SEARCH, key_pool[0], '0, '0);
        send_op(OP_DELETE, key_pool[0], '0, '0);
        send_op(OP_INSERT, '0, '0, '0);
        send_op(OP_INSERT, '1, '1, '1);
        send_op(OP_INSERT, '0, '1, '1);
        send_op(OP_INSERT, key_pool[1], random_text(), random_text());
        send_op(OP_SEARCH, '0, '1, '1);
        send_op(OP_SEARCH, '1, '0, '0);
        send_op(OP_SEARCH, key_pool[2], '0, '0);
        send_op(OP_LIST,   '0, '0, '0);
        send_op(OP_DELETE, '0, '0, '0);
        send_op(OP_LIST,   '0, '0, '0);
        send_op(OP_DELETE, key_pool[1], '0, '0);
        send_op(OP_DELETE, '1, '0, '0);
        send_op(OP_LIST,   '0, '0, '0);
        drain_results();

        // Fill past capacity, then a duplicate on the full table and a full list.
        sent = 0;
        for (int i = 0; i < DEPTH + 4; i++) begin
            send_op(OP_INSERT, key_pool[i], random_text(), random_text());
            sent++;
        end
        send_op(OP_INSERT, key_pool[3], random_text(), random_text());
        send_op(OP_LIST,   '0, '0, '0);
        send_op(OP_DELETE, key_pool[0], '0, '0);
        send_op(OP_DELETE, key_pool[DEPTH - 1], '0, '0);
        send_op(OP_SEARCH, key_pool[DEPTH / 2], '0, '0);
        send_op(OP_LIST,   '0, '0, '0);
        sent += 6;

        // Random rounds of mixed traffic.
        round = 0;
        while (sent < RANDOM_ITEMS) begin
            mode = (round % 3 == 2) ? 2 : $urandom_range(0, 1);
            calm <= (round == 4);
            for (int i = 0; i < ROUND_LEN; i++) begin
                send_op(pick_op(mode), pick_key(), random_text(), random_text());
                sent++;
            end
            if (round == 2) begin
                drain_results();
            end
            round++;
        end
        calm <= 1'b0;

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d items: %0d insert, %0d list, %0d search, %0d delete.",
                 op_tally[0] + op_tally[1] + op_tally[2] + op_tally[3],
                 op_tally[OP_INSERT], op_tally[OP_LIST], op_tally[OP_SEARCH],
                 op_tally[OP_DELETE]);
        $display("%0d result items compared, including fill-to-full and shift cases.",
                 checked);
        if (fail_count == 0) begin
            $display("keyed_symbol_table: match");
        end else begin
            $display("keyed_symbol_table: mismatch");
        end
        $finish;
    end

endmodule

### keyed_symbol_table.f
+incdir+sv
sv/kst_pkg.sv
sv/kst_ram.sv
sv/keyed_symbol_table.sv
sv/kst_checker.sv
tb/sv/kst_checker.sv
tb/sv/tb.sv
